// ----- rtl/lsra_pkg.sv -----
package lsra_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGISTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES     = 2'd2;

    // Fixed field widths.
    localparam int RCNT_W  = 3;
    localparam int FIRST_W = 4;
    localparam int SLOT_W  = 5;
    localparam int PHYS_W  = 5;
    localparam int OFFS_W  = 14;

    // Reset values of the configuration registers.
    localparam logic [RCNT_W-1:0]  RESET_REGISTER_COUNT = 3'd6;
    localparam logic [FIRST_W-1:0] RESET_FIRST_REGISTER = 4'd2;
    localparam logic [SLOT_W-1:0]  RESET_SLOT_BYTES     = 5'd4;

    // Spill offsets saturate at the largest value the offset field holds.
    localparam logic [OFFS_W-1:0] OFFSET_MAX = '1;

    // Classification of one interval, passed from the front to the back.
    typedef struct packed {
        logic new_func;
        logic alloc;
    } t_cls;

    // Placement engine states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLACE,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/linear_scan_register_allocator.sv -----
// Linear-scan register allocator for one register class. Each pushed word is
// one live interval, expected in order of start and then end; each interval
// in the class with a defined start yields one result word (its register or
// its spill slot), or two when it takes the register of an active interval
// that ends later, in which case the displaced temporary follows as spilled.
// Words with new_function set restart the active set, free registers and
// spill count before they are handled; out-of-class or undefined intervals
// yield no result. The front side takes a word in any cycle while its
// two-word queue has room. The single placement engine retires ended
// intervals, places the new one and, after a displacement, emits the second
// result; it waits while the output queue is full, takes skipped words
// straight from the queue, and finishes an interval before the next, since
// it works on the active set left by the previous interval. Results wait in
// a four-word output queue. Configuration writes are taken at once (ready is
// always high) and must be made only while the block holds no work.
module linear_scan_register_allocator #(
    parameter int MAX_REGS  = 6,
    parameter int MAX_TEMPS = 1024,
    parameter int POS_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input queue side.
    input  logic                                push,
    output logic                                full,
    input  logic                                i_new_function,
    input  logic                                i_in_class,
    input  logic [$clog2(MAX_TEMPS)-1:0]        i_temp_index,
    input  logic signed [POS_BITS:0]            i_def_position,
    input  logic signed [POS_BITS:0]            i_use_position,
    // Result queue side.
    output logic                                empty,
    input  logic                                pop,
    output logic [$clog2(MAX_TEMPS)-1:0]        o_out_temp,
    output logic                                o_spilled,
    output logic [lsra_pkg::PHYS_W-1:0]         o_phys_register,
    output logic [lsra_pkg::OFFS_W-1:0]         o_slot_offset,
    output logic [$clog2(MAX_TEMPS+1)-1:0]      o_spill_total,
    output logic                                o_last_of_run,
    // Configuration write channel.
    input  logic                                valid,
    output logic                                ready,
    input  logic [lsra_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsra_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int TEMP_W  = $clog2(MAX_TEMPS);
    localparam int SPILL_W = $clog2(MAX_TEMPS + 1);
    localparam int POS_W   = POS_BITS + 1;
    localparam int CLS_W   = $bits(lsra_pkg::t_cls);
    localparam int MID_W   = CLS_W + TEMP_W + 2 * POS_W;
    localparam int OUT_W   = TEMP_W + 1 + lsra_pkg::PHYS_W + lsra_pkg::OFFS_W + SPILL_W + 1;

    // Configuration registers.
    logic [lsra_pkg::RCNT_W-1:0]  r_register_count;
    logic [lsra_pkg::FIRST_W-1:0] r_first_register;
    logic [lsra_pkg::SLOT_W-1:0]  r_slot_bytes;

    // Front to queue.
    logic                    f_wr;
    lsra_pkg::t_cls          f_cls;
    logic [TEMP_W-1:0]       f_temp;
    logic signed [POS_W-1:0] f_def;
    logic signed [POS_W-1:0] f_end;
    logic [MID_W-1:0]        mid_wr_data;
    logic [MID_W-1:0]        mid_rd_data;
    logic                    mid_full;
    logic                    mid_empty;

    // Queue to back.
    logic                    b_pop;
    lsra_pkg::t_cls          b_cls;
    logic [TEMP_W-1:0]       b_temp;
    logic signed [POS_W-1:0] b_def;
    logic signed [POS_W-1:0] b_end;

    // Back to result queue.
    logic                          res_wr;
    logic [TEMP_W-1:0]             res_temp;
    logic                          res_spilled;
    logic [lsra_pkg::PHYS_W-1:0]   res_phys;
    logic [lsra_pkg::OFFS_W-1:0]   res_offs;
    logic [SPILL_W-1:0]            res_total;
    logic                          res_last;
    logic [OUT_W-1:0]              out_wr_data;
    logic [OUT_W-1:0]              out_rd_data;
    logic                          out_full;

    // Configuration writes are always taken.
    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_register_count <= lsra_pkg::RESET_REGISTER_COUNT;
            r_first_register <= lsra_pkg::RESET_FIRST_REGISTER;
            r_slot_bytes     <= lsra_pkg::RESET_SLOT_BYTES;
        end else if (valid && ready) begin
            case (i_cfg_index)
                lsra_pkg::CFG_REGISTER_COUNT: begin
                    r_register_count <= i_cfg_data[lsra_pkg::RCNT_W-1:0];
                end
                lsra_pkg::CFG_FIRST_REGISTER: begin
                    r_first_register <= i_cfg_data[lsra_pkg::FIRST_W-1:0];
                end
                lsra_pkg::CFG_SLOT_BYTES: begin
                    r_slot_bytes <= i_cfg_data[lsra_pkg::SLOT_W-1:0];
                end
                default: begin
                    r_slot_bytes <= r_slot_bytes;
                end
            endcase
        end
    end

    // Front: accept and classify intervals.
    lsra_front #(
        .TEMP_W (TEMP_W),
        .POS_W  (POS_W)
    ) u_front (
        .i_push         (push),
        .i_q_full       (mid_full),
        .i_new_function (i_new_function),
        .i_in_class     (i_in_class),
        .i_temp_index   (i_temp_index),
        .i_def_position (i_def_position),
        .i_use_position (i_use_position),
        .o_full         (full),
        .o_q_wr         (f_wr),
        .o_cls          (f_cls),
        .o_temp         (f_temp),
        .o_def          (f_def),
        .o_end          (f_end)
    );

    assign mid_wr_data = {f_cls, f_temp, f_def, f_end};

    // Short queue between classification and placement.
    lsra_fifo #(
        .WIDTH (MID_W),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (f_wr),
        .i_wr_data (mid_wr_data),
        .i_rd      (b_pop),
        .o_rd_data (mid_rd_data),
        .o_full    (mid_full),
        .o_empty   (mid_empty)
    );

    assign {b_cls, b_temp, b_def, b_end} = mid_rd_data;

    // Back: retire, place and report.
    lsra_back #(
        .MAX_REGS  (MAX_REGS),
        .MAX_TEMPS (MAX_TEMPS),
        .POS_BITS  (POS_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_register_count (r_register_count),
        .i_first_register (r_first_register),
        .i_slot_bytes     (r_slot_bytes),
        .i_q_empty        (mid_empty),
        .o_q_pop          (b_pop),
        .i_q_cls          (b_cls),
        .i_q_temp         (b_temp),
        .i_q_def          (b_def),
        .i_q_end          (b_end),
        .i_out_full       (out_full),
        .o_out_wr         (res_wr),
        .o_res_temp       (res_temp),
        .o_res_spilled    (res_spilled),
        .o_res_phys       (res_phys),
        .o_res_offs       (res_offs),
        .o_res_total      (res_total),
        .o_res_last       (res_last)
    );

    assign out_wr_data = {res_temp, res_spilled, res_phys, res_offs, res_total, res_last};

    // Result queue toward the consumer.
    lsra_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (4)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_wr),
        .i_wr_data (out_wr_data),
        .i_rd      (pop),
        .o_rd_data (out_rd_data),
        .o_full    (out_full),
        .o_empty   (empty)
    );

    assign {o_out_temp, o_spilled, o_phys_register, o_slot_offset,
            o_spill_total, o_last_of_run} = out_rd_data;

endmodule

// ----- rtl/lsra_fifo.sv -----
module lsra_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_fire;
    logic             rd_fire;

    // Handshake status.
    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr_fire   = i_wr && !o_full;
    assign rd_fire   = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; the fill count guards every read.
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/lsra_front.sv -----
module lsra_front #(
    parameter int TEMP_W = 10,
    parameter int POS_W  = 17
) (
    input  logic                     i_push,
    input  logic                     i_q_full,
    input  logic                     i_new_function,
    input  logic                     i_in_class,
    input  logic [TEMP_W-1:0]        i_temp_index,
    input  logic signed [POS_W-1:0]  i_def_position,
    input  logic signed [POS_W-1:0]  i_use_position,
    output logic                     o_full,
    output logic                     o_q_wr,
    output lsra_pkg::t_cls           o_cls,
    output logic [TEMP_W-1:0]        o_temp,
    output logic signed [POS_W-1:0]  o_def,
    output logic signed [POS_W-1:0]  o_end
);

    // The input side is full exactly when the queue to the back is full.
    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

    // Classify the interval: only defined temporaries of this class get a
    // placement; everything else only carries a possible function restart.
    always_comb begin
        o_cls.new_func = i_new_function;
        o_cls.alloc    = i_in_class && (i_def_position >= 0);
    end

    // The interval ends at its last use, or at its definition if that is later.
    assign o_end  = (i_use_position >= i_def_position) ? i_use_position : i_def_position;
    assign o_temp = i_temp_index;
    assign o_def  = i_def_position;

endmodule

// ----- rtl/lsra_back.sv -----
module lsra_back #(
    parameter int MAX_REGS  = 6,
    parameter int MAX_TEMPS = 1024,
    parameter int POS_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [lsra_pkg::RCNT_W-1:0]         i_register_count,
    input  logic [lsra_pkg::FIRST_W-1:0]        i_first_register,
    input  logic [lsra_pkg::SLOT_W-1:0]         i_slot_bytes,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    input  lsra_pkg::t_cls                      i_q_cls,
    input  logic [$clog2(MAX_TEMPS)-1:0]        i_q_temp,
    input  logic signed [POS_BITS:0]            i_q_def,
    input  logic signed [POS_BITS:0]            i_q_end,
    input  logic                                i_out_full,
    output logic                                o_out_wr,
    output logic [$clog2(MAX_TEMPS)-1:0]        o_res_temp,
    output logic                                o_res_spilled,
    output logic [lsra_pkg::PHYS_W-1:0]         o_res_phys,
    output logic [lsra_pkg::OFFS_W-1:0]         o_res_offs,
    output logic [$clog2(MAX_TEMPS+1)-1:0]      o_res_total,
    output logic                                o_res_last
);

    localparam int TEMP_W  = $clog2(MAX_TEMPS);
    localparam int SPILL_W = $clog2(MAX_TEMPS + 1);
    localparam int POS_W   = POS_BITS + 1;
    localparam int RW      = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW      = $clog2(MAX_REGS + 1);
    localparam int PROD_W  = SPILL_W + lsra_pkg::SLOT_W;
    localparam logic [SPILL_W-1:0]  SPILL_MAX = SPILL_W'(MAX_TEMPS);
    localparam logic [MAX_REGS-1:0] ALL_FREE  = '1;

    // Control state.
    lsra_pkg::t_state r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [MAX_REGS-1:0] r_mask, n_mask;
    logic [SPILL_W-1:0]  r_spill, n_spill;

    // Active set, kept sorted by ascending end; equal ends in arrival order.
    logic [TEMP_W-1:0]       r_ent_temp [MAX_REGS];
    logic [TEMP_W-1:0]       n_ent_temp [MAX_REGS];
    logic signed [POS_W-1:0] r_ent_end  [MAX_REGS];
    logic signed [POS_W-1:0] n_ent_end  [MAX_REGS];
    logic [RW-1:0]           r_ent_reg  [MAX_REGS];
    logic [RW-1:0]           n_ent_reg  [MAX_REGS];

    // Interval in flight and the pending spill word of a displaced interval.
    logic [TEMP_W-1:0]          r_cur_temp, n_cur_temp;
    logic signed [POS_W-1:0]    r_cur_end, n_cur_end;
    logic [TEMP_W-1:0]          r_vic_temp, n_vic_temp;
    logic [lsra_pkg::OFFS_W-1:0] r_vic_offs, n_vic_offs;
    logic [SPILL_W-1:0]         r_vic_total, n_vic_total;

    // Retire step signals.
    logic [CW-1:0]       cnt;
    logic                cnt_zero;
    logic [CW-1:0]       base_count;
    logic [MAX_REGS-1:0] base_mask;
    logic [SPILL_W-1:0]  base_spill;
    logic                do_retire;
    logic [MAX_REGS-1:0] ret;
    logic [MAX_REGS-1:0] freed;
    logic [CW-1:0]       ret_n;
    logic [TEMP_W-1:0]       sh_temp [MAX_REGS];
    logic signed [POS_W-1:0] sh_end  [MAX_REGS];
    logic [RW-1:0]           sh_reg  [MAX_REGS];

    // Placement step signals.
    logic                found;
    logic [RW-1:0]       free_k;
    logic [CW-1:0]       vi_full;
    logic [RW-1:0]       vi;
    logic                steal;
    logic                to_reg;
    logic [RW-1:0]       place_reg;
    logic [CW-1:0]       lc;
    logic [MAX_REGS-1:0] gt;
    logic [CW-1:0]       at;
    logic [PROD_W-1:0]   prod;
    logic [lsra_pkg::OFFS_W-1:0] offs;
    logic [SPILL_W-1:0]  spill_inc;
    logic [SPILL_W-1:0]  place_spill;
    logic                idle_go;
    logic                out_go;

    // Registers at or above the configured count are never handed out.
    assign cnt = (int'(i_register_count) > MAX_REGS) ? CW'(MAX_REGS)
                                                      : CW'(i_register_count);
    assign cnt_zero = (cnt == '0);

    assign idle_go = (r_state == lsra_pkg::ST_IDLE) && !i_q_empty;
    assign out_go  = !i_out_full;

    // Retire step: a new function starts from an empty set, then for a placed
    // interval every active interval that ended before its start gives its
    // register back. The set is sorted by end, so these entries form its front.
    always_comb begin
        int src;
        base_count = i_q_cls.new_func ? '0 : r_count;
        base_mask  = i_q_cls.new_func ? ALL_FREE : r_mask;
        base_spill = i_q_cls.new_func ? '0 : r_spill;
        do_retire  = i_q_cls.alloc && !cnt_zero;
        freed      = '0;
        for (int i = 0; i < MAX_REGS; i++) begin
            ret[i] = do_retire && (CW'(i) < base_count) && (r_ent_end[i] < i_q_def);
            if (ret[i]) begin
                freed[r_ent_reg[i]] = 1'b1;
            end
        end
        ret_n = CW'($countones(ret));
        for (int i = 0; i < MAX_REGS; i++) begin
            src = i + int'(ret_n);
            if (src < MAX_REGS) begin
                sh_temp[i] = r_ent_temp[RW'(src)];
                sh_end[i]  = r_ent_end[RW'(src)];
                sh_reg[i]  = r_ent_reg[RW'(src)];
            end else begin
                sh_temp[i] = r_ent_temp[i];
                sh_end[i]  = r_ent_end[i];
                sh_reg[i]  = r_ent_reg[i];
            end
        end
    end

    // Placement step: lowest free register, else steal from the interval that
    // ends last when it outlives the new one, else spill the new interval.
    always_comb begin
        found  = 1'b0;
        free_k = '0;
        for (int i = MAX_REGS - 1; i >= 0; i--) begin
            if (r_mask[i] && (CW'(i) < cnt)) begin
                found  = 1'b1;
                free_k = RW'(i);
            end
        end
        vi_full   = r_count - CW'(1);
        vi        = vi_full[RW-1:0];
        steal     = !cnt_zero && !found && (r_count != '0) && (r_ent_end[vi] > r_cur_end);
        to_reg    = !cnt_zero && (found || steal);
        place_reg = found ? free_k : r_ent_reg[vi];
        // A stolen entry leaves the set before the new one goes in.
        lc = found ? r_count : vi_full;
        for (int i = 0; i < MAX_REGS; i++) begin
            gt[i] = (CW'(i) < lc) && (r_ent_end[i] > r_cur_end);
        end
        at = lc - CW'($countones(gt));
        // Slot offset from the spill count before the increment.
        prod      = PROD_W'(r_spill) * PROD_W'(i_slot_bytes);
        offs      = (prod > PROD_W'(lsra_pkg::OFFSET_MAX)) ? lsra_pkg::OFFSET_MAX
                                                            : lsra_pkg::OFFS_W'(prod);
        spill_inc = (r_spill < SPILL_MAX) ? r_spill + SPILL_W'(1) : r_spill;
        place_spill = (to_reg && !steal) ? r_spill : spill_inc;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsra_pkg::ST_IDLE: begin
                if (idle_go && i_q_cls.alloc) begin
                    n_state = lsra_pkg::ST_PLACE;
                end
            end
            lsra_pkg::ST_PLACE: begin
                if (out_go) begin
                    n_state = steal ? lsra_pkg::ST_EMIT : lsra_pkg::ST_IDLE;
                end
            end
            lsra_pkg::ST_EMIT: begin
                if (out_go) begin
                    n_state = lsra_pkg::ST_IDLE;
                end
            end
            default: n_state = lsra_pkg::ST_IDLE;
        endcase
    end

    // Handshakes and the result word.
    always_comb begin
        o_q_pop       = 1'b0;
        o_out_wr      = 1'b0;
        o_res_temp    = r_cur_temp;
        o_res_spilled = !to_reg;
        o_res_phys    = '0;
        o_res_offs    = '0;
        o_res_total   = place_spill;
        o_res_last    = !steal;
        case (r_state)
            lsra_pkg::ST_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            lsra_pkg::ST_PLACE: begin
                o_out_wr = out_go;
                if (to_reg) begin
                    o_res_phys = lsra_pkg::PHYS_W'(place_reg)
                               + lsra_pkg::PHYS_W'(i_first_register);
                end else begin
                    o_res_offs = offs;
                end
            end
            lsra_pkg::ST_EMIT: begin
                o_out_wr      = out_go;
                o_res_temp    = r_vic_temp;
                o_res_spilled = 1'b1;
                o_res_offs    = r_vic_offs;
                o_res_total   = r_vic_total;
                o_res_last    = 1'b1;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // Next values of the active set and counters.
    always_comb begin
        n_count     = r_count;
        n_mask      = r_mask;
        n_spill     = r_spill;
        n_ent_temp  = r_ent_temp;
        n_ent_end   = r_ent_end;
        n_ent_reg   = r_ent_reg;
        n_cur_temp  = r_cur_temp;
        n_cur_end   = r_cur_end;
        n_vic_temp  = r_vic_temp;
        n_vic_offs  = r_vic_offs;
        n_vic_total = r_vic_total;
        if (idle_go) begin
            n_count    = base_count - ret_n;
            n_mask     = base_mask | freed;
            n_spill    = base_spill;
            n_ent_temp = sh_temp;
            n_ent_end  = sh_end;
            n_ent_reg  = sh_reg;
            n_cur_temp = i_q_temp;
            n_cur_end  = i_q_end;
        end else if ((r_state == lsra_pkg::ST_PLACE) && out_go) begin
            n_spill = place_spill;
            if (to_reg) begin
                n_count = lc + CW'(1);
                if (found) begin
                    n_mask[free_k] = 1'b0;
                end
                // Insert after every entry that does not end later.
                for (int i = 0; i < MAX_REGS; i++) begin
                    if (CW'(i) == at) begin
                        n_ent_temp[i] = r_cur_temp;
                        n_ent_end[i]  = r_cur_end;
                        n_ent_reg[i]  = place_reg;
                    end else if ((CW'(i) > at) && (i > 0)) begin
                        n_ent_temp[i] = r_ent_temp[RW'(i - 1)];
                        n_ent_end[i]  = r_ent_end[RW'(i - 1)];
                        n_ent_reg[i]  = r_ent_reg[RW'(i - 1)];
                    end
                end
            end
            n_vic_temp  = r_ent_temp[vi];
            n_vic_offs  = offs;
            n_vic_total = place_spill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsra_pkg::ST_IDLE;
            r_count <= '0;
            r_mask  <= ALL_FREE;
            r_spill <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mask  <= n_mask;
            r_spill <= n_spill;
        end
    end

    // Payload registers; entries beyond the count are never read.
    always_ff @(posedge i_clk) begin
        r_ent_temp  <= n_ent_temp;
        r_ent_end   <= n_ent_end;
        r_ent_reg   <= n_ent_reg;
        r_cur_temp  <= n_cur_temp;
        r_cur_end   <= n_cur_end;
        r_vic_temp  <= n_vic_temp;
        r_vic_offs  <= n_vic_offs;
        r_vic_total <= n_vic_total;
    end

endmodule
